### rtl/fmm_pkg.sv
// Shared types, constants and binary32 helper functions for the matrix multiply block.
// Used by fmm_fmul, fmm_fadd and float_matrix_multiply_top; depends on nothing else.
package fmm_pkg;

    localparam int MAX_DIM_DEF = 8;
    localparam int DIM_W       = 4;
    localparam int KIND_W      = 2;
    localparam int IDX_W       = 6;
    localparam int WORD_W      = 32;
    localparam int CFG_IDX_W   = 2;

    localparam logic [KIND_W-1:0] KIND_LOAD_A = 2'd0;
    localparam logic [KIND_W-1:0] KIND_LOAD_B = 2'd1;
    localparam logic [KIND_W-1:0] KIND_START  = 2'd2;

    localparam logic [CFG_IDX_W-1:0] REG_ROWS  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_INNER = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_COLS  = 2'd2;

    localparam logic [WORD_W-1:0] CANON_NAN = 32'h7FC0_0000;
    localparam logic [WORD_W-1:0] FP_ZERO   = 32'h0000_0000;

    typedef struct packed {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  element_index;
        logic [WORD_W-1:0] element_value;
    } in_word_t;

    typedef struct packed {
        logic [WORD_W-1:0] product_value;
        logic              is_last;
    } out_word_t;

    function automatic logic [5:0] lzc48(input logic [47:0] v);
        logic [5:0] n;
        n = 6'd48;
        for (int i = 0; i < 48; i++)
        begin
            if (v[i])
            begin
                n = 6'(47 - i);
            end
        end
        return n;
    endfunction

    // Rounds a normalised significand (leading one at bit 26, sticky at bit 0)
    // to binary32 with round-to-nearest-even, including subnormal and overflow results.
    function automatic logic [31:0] fp_round(input logic sgn, input logic signed [11:0] e,
                                             input logic [26:0] m);
        logic [26:0]        mm;
        logic [26:0]        mask;
        logic [11:0]        shf;
        logic [4:0]         sh;
        logic               sub;
        logic               inc;
        logic [24:0]        sig;
        logic signed [11:0] ef;
        logic [31:0]        r;
        sub = (e < 12'sd1);
        shf = 12'(12'sd1 - e);
        if (!sub)
        begin
            sh = 5'd0;
        end
        else if (shf > 12'd27)
        begin
            sh = 5'd27;
        end
        else
        begin
            sh = shf[4:0];
        end
        mask  = ~(27'h7FF_FFFF << sh);
        mm    = m >> sh;
        mm[0] = mm[0] | (|(m & mask));
        inc   = mm[2] & (mm[1] | mm[0] | mm[3]);
        sig   = {1'b0, mm[26:3]} + 25'(inc);
        ef    = e + 12'(sig[24]);
        if (sub)
        begin
            r = {sgn, 7'd0, sig[23], sig[22:0]};
        end
        else if (ef >= 12'sd255)
        begin
            r = {sgn, 8'hFF, 23'd0};
        end
        else
        begin
            r = {sgn, ef[7:0], (sig[24] ? 23'd0 : sig[22:0])};
        end
        return r;
    endfunction

endpackage

### rtl/fmm_fmul.sv
// Three-stage binary32 multiplier with round-to-nearest-even and a canonical NaN.
// Depends on fmm_pkg for the normalisation and rounding helpers.
module fmm_fmul
    import fmm_pkg::*;
(
    input  logic              clk,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic [WORD_W-1:0] y
);

    logic [7:0]         ea_eff;
    logic [7:0]         eb_eff;
    logic [23:0]        ma;
    logic [23:0]        mb;
    logic               a_nan, b_nan, a_inf, b_inf, a_zero, b_zero;

    logic               s1_sign_reg, s1_nan_reg, s1_inf_reg, s1_zero_reg;
    logic [47:0]        s1_prod_reg;
    logic signed [11:0] s1_exp_reg;

    logic               s2_sign_reg, s2_nan_reg, s2_inf_reg, s2_zero_reg;
    logic signed [11:0] s2_exp_reg;
    logic [26:0]        s2_mant_reg;

    logic [5:0]         lz;
    logic [47:0]        prod_sh;
    logic [WORD_W-1:0]  y_reg;

    always_comb
    begin
        ea_eff = (a[30:23] == 8'd0) ? 8'd1 : a[30:23];
        eb_eff = (b[30:23] == 8'd0) ? 8'd1 : b[30:23];
        ma     = {(a[30:23] != 8'd0), a[22:0]};
        mb     = {(b[30:23] != 8'd0), b[22:0]};
        a_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan  = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf  = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        a_zero = (a[30:0] == 31'd0);
        b_zero = (b[30:0] == 31'd0);
    end

    always_ff @(posedge clk)
    begin
        s1_sign_reg <= a[31] ^ b[31];
        s1_nan_reg  <= a_nan || b_nan || (a_inf && b_zero) || (b_inf && a_zero);
        s1_inf_reg  <= a_inf || b_inf;
        s1_zero_reg <= a_zero || b_zero;
        s1_prod_reg <= ma * mb;
        s1_exp_reg  <= 12'(ea_eff) + 12'(eb_eff) - 12'd126;
    end

    always_comb
    begin
        lz      = lzc48(s1_prod_reg);
        prod_sh = s1_prod_reg << lz;
    end

    always_ff @(posedge clk)
    begin
        s2_sign_reg <= s1_sign_reg;
        s2_nan_reg  <= s1_nan_reg;
        s2_inf_reg  <= s1_inf_reg;
        s2_zero_reg <= s1_zero_reg;
        s2_exp_reg  <= s1_exp_reg - 12'(lz);
        s2_mant_reg <= {prod_sh[47:22], |prod_sh[21:0]};
    end

    always_ff @(posedge clk)
    begin
        if (s2_nan_reg)
        begin
            y_reg <= CANON_NAN;
        end
        else if (s2_inf_reg)
        begin
            y_reg <= {s2_sign_reg, 8'hFF, 23'd0};
        end
        else if (s2_zero_reg)
        begin
            y_reg <= {s2_sign_reg, 31'd0};
        end
        else
        begin
            y_reg <= fp_round(s2_sign_reg, s2_exp_reg, s2_mant_reg);
        end
    end

    assign y = y_reg;

endmodule

### rtl/fmm_fadd.sv
// Four-stage binary32 adder: align, add, normalise, round to nearest even.
// Depends on fmm_pkg for the normalisation and rounding helpers.
module fmm_fadd
    import fmm_pkg::*;
(
    input  logic              clk,
    input  logic [WORD_W-1:0] a,
    input  logic [WORD_W-1:0] b,
    output logic [WORD_W-1:0] y
);

    logic [WORD_W-1:0]  big, lesser;
    logic [7:0]         eb_eff, es_eff, d;
    logic [26:0]        mbig, ms, ms_tmp, ms_lost, ms_al;
    logic               a_nan, b_nan, a_inf, b_inf;

    logic               s1_sign_reg, s1_sub_reg, s1_nan_reg, s1_inf_reg, s1_isign_reg;
    logic               s1_zsign_reg;
    logic [7:0]         s1_exp_reg;
    logic [26:0]        s1_big_reg, s1_small_reg;

    logic               s2_sign_reg, s2_nan_reg, s2_inf_reg, s2_isign_reg, s2_zsign_reg;
    logic [7:0]         s2_exp_reg;
    logic [27:0]        s2_sum_reg;

    logic               s3_sign_reg, s3_nan_reg, s3_inf_reg, s3_isign_reg, s3_zsign_reg;
    logic               s3_zero_reg;
    logic signed [11:0] s3_exp_reg;
    logic [26:0]        s3_mant_reg;

    logic [5:0]         lz;
    logic [27:0]        sum_sh;
    logic [WORD_W-1:0]  y_reg;

    always_comb
    begin
        a_nan   = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        b_nan   = (b[30:23] == 8'hFF) && (b[22:0] != 23'd0);
        a_inf   = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        b_inf   = (b[30:23] == 8'hFF) && (b[22:0] == 23'd0);
        big     = (a[30:0] >= b[30:0]) ? a : b;
        lesser  = (a[30:0] >= b[30:0]) ? b : a;
        eb_eff  = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        es_eff  = (lesser[30:23] == 8'd0) ? 8'd1 : lesser[30:23];
        d       = eb_eff - es_eff;
        mbig    = {(big[30:23] != 8'd0), big[22:0], 3'b000};
        ms      = {(lesser[30:23] != 8'd0), lesser[22:0], 3'b000};
        ms_tmp  = ms >> d[4:0];
        ms_lost = ms & ~(27'h7FF_FFFF << d[4:0]);
        if (d >= 8'd27)
        begin
            ms_al = {26'd0, |ms};
        end
        else
        begin
            ms_al = {ms_tmp[26:1], ms_tmp[0] | (|ms_lost)};
        end
    end

    always_ff @(posedge clk)
    begin
        s1_sign_reg  <= big[31];
        s1_sub_reg   <= a[31] ^ b[31];
        s1_nan_reg   <= a_nan || b_nan || (a_inf && b_inf && (a[31] != b[31]));
        s1_inf_reg   <= a_inf || b_inf;
        s1_isign_reg <= a_inf ? a[31] : b[31];
        s1_zsign_reg <= a[31] & b[31];
        s1_exp_reg   <= eb_eff;
        s1_big_reg   <= mbig;
        s1_small_reg <= ms_al;
    end

    always_ff @(posedge clk)
    begin
        s2_sign_reg  <= s1_sign_reg;
        s2_nan_reg   <= s1_nan_reg;
        s2_inf_reg   <= s1_inf_reg;
        s2_isign_reg <= s1_isign_reg;
        s2_zsign_reg <= s1_zsign_reg;
        s2_exp_reg   <= s1_exp_reg;
        if (s1_sub_reg)
        begin
            s2_sum_reg <= {1'b0, s1_big_reg} - {1'b0, s1_small_reg};
        end
        else
        begin
            s2_sum_reg <= {1'b0, s1_big_reg} + {1'b0, s1_small_reg};
        end
    end

    always_comb
    begin
        lz     = lzc48({s2_sum_reg, 20'hF_FFFF});
        sum_sh = s2_sum_reg << lz;
    end

    always_ff @(posedge clk)
    begin
        s3_sign_reg  <= s2_sign_reg;
        s3_nan_reg   <= s2_nan_reg;
        s3_inf_reg   <= s2_inf_reg;
        s3_isign_reg <= s2_isign_reg;
        s3_zsign_reg <= s2_zsign_reg;
        s3_zero_reg  <= (s2_sum_reg == 28'd0);
        s3_exp_reg   <= 12'(s2_exp_reg) + 12'd1 - 12'(lz);
        s3_mant_reg  <= {sum_sh[27:2], |sum_sh[1:0]};
    end

    always_ff @(posedge clk)
    begin
        if (s3_nan_reg)
        begin
            y_reg <= CANON_NAN;
        end
        else if (s3_inf_reg)
        begin
            y_reg <= {s3_isign_reg, 8'hFF, 23'd0};
        end
        else if (s3_zero_reg)
        begin
            y_reg <= {s3_zsign_reg, 31'd0};
        end
        else
        begin
            y_reg <= fp_round(s3_sign_reg, s3_exp_reg, s3_mant_reg);
        end
    end

    assign y = y_reg;

endmodule

### rtl/float_matrix_multiply_top.sv
// Top level of the binary32 matrix multiply block: stores for A and B, sequencer, result register.
// Depends on fmm_pkg, fmm_fmul and fmm_fadd.
//
//  channel | direction | handshake          | word
//  in      | input     | in_valid/in_stall  | in_word_t: kind, element_index, element_value
//  out     | output    | out_valid/out_stall| out_word_t: product_value, is_last
//  cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// Words are taken only while the sequencer is idle. A start word computes M*N results; each
// multiply-add is one store read, three multiplier stages, four adder stages and the
// accumulator write, all in sequence on a single multiplier and adder.
// Reset clears the sequencer, the dimension registers (to one) and the result valid flag;
// the stores are not cleared. A stalled result holds the sequencer in its emit state.
module float_matrix_multiply_top
    import fmm_pkg::*;
#(
    parameter int MAX_DIM = MAX_DIM_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 in_valid,
    output logic                 in_stall,
    input  in_word_t             in_word,
    output logic                 out_valid,
    input  logic                 out_stall,
    output out_word_t            out_word,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0]     cfg_data
);

    localparam int DEPTH = MAX_DIM * MAX_DIM;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_READ = 2'd1;
    localparam logic [1:0] ST_WAIT = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    localparam logic [2:0] ACC_WAIT = 3'd7;

    logic [1:0]        state_reg, state_next;
    logic [DIM_W-1:0]  rows_reg, inner_reg, cols_reg;
    logic [DIM_W-1:0]  m_eff, k_eff, n_eff;
    logic [DIM_W-1:0]  i_reg, i_next, j_reg, j_next, k_reg, k_next;
    logic [AW-1:0]     a_addr_reg, a_addr_next, b_addr_reg, b_addr_next;
    logic [AW-1:0]     a_row_reg, a_row_next;
    logic [2:0]        cnt_reg, cnt_next;
    logic [WORD_W-1:0] acc_reg, acc_next;
    logic [WORD_W-1:0] a_rd_reg, b_rd_reg;
    logic [WORD_W-1:0] mul_y, add_y;
    logic              out_valid_reg, out_valid_next;
    out_word_t         out_word_reg, out_word_next;
    logic              in_take, out_load, last_elem;

    logic [WORD_W-1:0] a_mem [DEPTH];
    logic [WORD_W-1:0] b_mem [DEPTH];

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] d);
        logic [DIM_W-1:0] r;
        if (d == '0)
        begin
            r = DIM_W'(1);
        end
        else if (int'(d) > MAX_DIM)
        begin
            r = DIM_W'(MAX_DIM);
        end
        else
        begin
            r = d;
        end
        return r;
    endfunction

    assign m_eff     = clamp_dim(rows_reg);
    assign k_eff     = clamp_dim(inner_reg);
    assign n_eff     = clamp_dim(cols_reg);
    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != ST_IDLE);
    assign in_take   = in_valid && !in_stall;
    assign last_elem = (i_reg == m_eff - DIM_W'(1)) && (j_reg == n_eff - DIM_W'(1));
    assign out_load  = (state_reg == ST_EMIT) && (!out_valid_reg || !out_stall);
    assign out_valid = out_valid_reg;
    assign out_word  = out_word_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rows_reg  <= DIM_W'(1);
            inner_reg <= DIM_W'(1);
            cols_reg  <= DIM_W'(1);
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                REG_ROWS:  rows_reg  <= cfg_data;
                REG_INNER: inner_reg <= cfg_data;
                REG_COLS:  cols_reg  <= cfg_data;
                default:   ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take && (int'(in_word.element_index) < DEPTH))
        begin
            if (in_word.kind == KIND_LOAD_A)
            begin
                a_mem[in_word.element_index[AW-1:0]] <= in_word.element_value;
            end
            if (in_word.kind == KIND_LOAD_B)
            begin
                b_mem[in_word.element_index[AW-1:0]] <= in_word.element_value;
            end
        end
        if (state_reg == ST_READ)
        begin
            a_rd_reg <= a_mem[a_addr_reg];
            b_rd_reg <= b_mem[b_addr_reg];
        end
    end

    fmm_fmul u_fmul (
        .clk (clk),
        .a   (a_rd_reg),
        .b   (b_rd_reg),
        .y   (mul_y)
    );

    fmm_fadd u_fadd (
        .clk (clk),
        .a   (acc_reg),
        .b   (mul_y),
        .y   (add_y)
    );

    always_comb
    begin
        state_next     = state_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        a_addr_next    = a_addr_reg;
        b_addr_next    = b_addr_reg;
        a_row_next     = a_row_reg;
        cnt_next       = cnt_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg && out_stall;
        out_word_next  = out_word_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_take && (in_word.kind == KIND_START))
                begin
                    i_next      = '0;
                    j_next      = '0;
                    k_next      = '0;
                    a_addr_next = '0;
                    b_addr_next = '0;
                    a_row_next  = '0;
                    acc_next    = FP_ZERO;
                    state_next  = ST_READ;
                end
            end
            ST_READ:
            begin
                cnt_next   = '0;
                state_next = ST_WAIT;
            end
            ST_WAIT:
            begin
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == ACC_WAIT)
                begin
                    acc_next = add_y;
                    if (k_reg == k_eff - DIM_W'(1))
                    begin
                        state_next = ST_EMIT;
                    end
                    else
                    begin
                        k_next      = k_reg + DIM_W'(1);
                        a_addr_next = a_addr_reg + AW'(1);
                        b_addr_next = AW'(b_addr_reg + AW'(n_eff));
                        state_next  = ST_READ;
                    end
                end
            end
            ST_EMIT:
            begin
                if (out_load)
                begin
                    out_valid_next              = 1'b1;
                    out_word_next.product_value = acc_reg;
                    out_word_next.is_last       = last_elem;
                    acc_next                    = FP_ZERO;
                    k_next                      = '0;
                    if (last_elem)
                    begin
                        state_next = ST_IDLE;
                    end
                    else if (j_reg == n_eff - DIM_W'(1))
                    begin
                        i_next      = i_reg + DIM_W'(1);
                        j_next      = '0;
                        a_row_next  = AW'(a_row_reg + AW'(k_eff));
                        a_addr_next = AW'(a_row_reg + AW'(k_eff));
                        b_addr_next = '0;
                        state_next  = ST_READ;
                    end
                    else
                    begin
                        j_next      = j_reg + DIM_W'(1);
                        a_addr_next = a_row_reg;
                        b_addr_next = AW'(j_reg + DIM_W'(1));
                        state_next  = ST_READ;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            out_valid_reg <= 1'b0;
            i_reg         <= '0;
            j_reg         <= '0;
            k_reg         <= '0;
            cnt_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            i_reg         <= i_next;
            j_reg         <= j_next;
            k_reg         <= k_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_addr_reg   <= a_addr_next;
        b_addr_reg   <= b_addr_next;
        a_row_reg    <= a_row_next;
        acc_reg      <= acc_next;
        out_word_reg <= out_word_next;
    end

    a_k_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != ST_IDLE) |-> (k_reg < k_eff))
        else $error("inner index beyond the inner dimension");

    a_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (out_load && last_elem) |=> (state_reg == ST_IDLE))
        else $error("sequencer did not return to idle after the last element");

    a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && out_stall) |-> !out_load)
        else $error("a pending result word was overwritten");

endmodule

### verif/tb_top.sv
// Self-checking testbench for float_matrix_multiply_top: loads A and B, starts products and
// checks every result word against a bit-accurate binary32 predictor or a row's given value.
// Depends on fmm_pkg and the RTL of float_matrix_multiply_top.
module tb_top;
    import fmm_pkg::*;

    localparam logic [KIND_W-1:0]    KIND_UNUSED = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED  = 2'd3;
    localparam int STORE_DEPTH   = MAX_DIM_DEF * MAX_DIM_DEF;
    localparam int QUIET_LIMIT   = 20000;
    localparam int SETTLE_CYCLES = 20;

    typedef struct {
        logic [KIND_W-1:0] kind;
        logic [IDX_W-1:0]  index;
        logic [WORD_W-1:0] value;
        bit                typed;
        logic [WORD_W-1:0] product;
    } stim_row_t;

    logic                 clk;
    logic                 rst_n;
    logic                 in_valid;
    logic                 in_stall;
    in_word_t             in_word;
    logic                 out_valid;
    logic                 out_stall;
    out_word_t            out_word;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [DIM_W-1:0]     cfg_data;

    logic [WORD_W-1:0] a_copy [STORE_DEPTH];
    logic [WORD_W-1:0] b_copy [STORE_DEPTH];
    bit                a_written [STORE_DEPTH];
    bit                b_written [STORE_DEPTH];
    logic [DIM_W-1:0]  rows_reg;
    logic [DIM_W-1:0]  inner_reg;
    logic [DIM_W-1:0]  cols_reg;
    out_word_t         product_queue [$];
    int                idle_mode;
    int                errors;
    int                words_sent;
    int                starts_sent;
    int                results_seen;
    int                quiet_cycles;

    float_matrix_multiply_top uut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .in_word   (in_word),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_word  (out_word),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic logic [31:0] fp32_round_pack(input logic sgn, input logic [127:0] mag,
                                                    input int e);
        int           p;
        int           lsb;
        int           sh;
        logic [127:0] q;
        logic [127:0] rem;
        logic [127:0] half;
        if (mag == 128'd0)
        begin
            return {sgn, 31'd0};
        end
        p = 0;
        for (int i = 0; i < 128; i++)
        begin
            if (mag[i])
            begin
                p = i;
            end
        end
        lsb = p + e - 23;
        if (lsb < -149)
        begin
            lsb = -149;
        end
        sh = lsb - e;
        if (sh <= 0)
        begin
            q = mag << (-sh);
        end
        else if (sh > p + 1)
        begin
            q = 128'd0;
        end
        else
        begin
            q    = mag >> sh;
            rem  = mag & ((128'd1 << sh) - 128'd1);
            half = 128'd1 << (sh - 1);
            if (rem > half || (rem == half && q[0]))
            begin
                q = q + 128'd1;
            end
        end
        if (q[24])
        begin
            q   = q >> 1;
            lsb = lsb + 1;
        end
        if (!q[23])
        begin
            return {sgn, 8'd0, q[22:0]};
        end
        if (lsb + 150 >= 255)
        begin
            return {sgn, 8'hFF, 23'd0};
        end
        return {sgn, 8'(lsb + 150), q[22:0]};
    endfunction

    function automatic bit fp32_is_nan(input logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] != 23'd0;
    endfunction

    function automatic bit fp32_is_inf(input logic [31:0] v);
        return v[30:23] == 8'hFF && v[22:0] == 23'd0;
    endfunction

    function automatic logic [23:0] fp32_sig(input logic [31:0] v);
        return (v[30:23] == 8'd0) ? {1'b0, v[22:0]} : {1'b1, v[22:0]};
    endfunction

    function automatic int fp32_exp(input logic [31:0] v);
        return (v[30:23] == 8'd0) ? -149 : int'(v[30:23]) - 150;
    endfunction

    function automatic logic [31:0] fp32_mul(input logic [31:0] a, input logic [31:0] b);
        logic sgn;
        sgn = a[31] ^ b[31];
        if (fp32_is_nan(a) || fp32_is_nan(b))
        begin
            return CANON_NAN;
        end
        if (fp32_is_inf(a) || fp32_is_inf(b))
        begin
            if (a[30:0] == 31'd0 || b[30:0] == 31'd0)
            begin
                return CANON_NAN;
            end
            return {sgn, 8'hFF, 23'd0};
        end
        return fp32_round_pack(sgn, 128'(fp32_sig(a)) * 128'(fp32_sig(b)),
                               fp32_exp(a) + fp32_exp(b));
    endfunction

    function automatic logic [31:0] fp32_add(input logic [31:0] a, input logic [31:0] b);
        logic [31:0]  big;
        logic [31:0]  lit;
        logic [127:0] bm;
        logic [127:0] sm;
        logic [127:0] mag;
        logic         sgn;
        int           d;
        int           s;
        if (fp32_is_nan(a) || fp32_is_nan(b))
        begin
            return CANON_NAN;
        end
        if (fp32_is_inf(a) && fp32_is_inf(b) && a[31] != b[31])
        begin
            return CANON_NAN;
        end
        if (fp32_is_inf(a))
        begin
            return a;
        end
        if (fp32_is_inf(b))
        begin
            return b;
        end
        if (fp32_exp(a) >= fp32_exp(b))
        begin
            big = a;
            lit = b;
        end
        else
        begin
            big = b;
            lit = a;
        end
        d  = fp32_exp(big) - fp32_exp(lit);
        s  = (d > 40) ? 40 : d;
        bm = 128'(fp32_sig(big)) << s;
        sm = 128'(fp32_sig(lit)) >> (d - s);
        if ((128'(fp32_sig(lit)) & ((128'd1 << (d - s)) - 128'd1)) != 128'd0)
        begin
            sm[0] = 1'b1;
        end
        if (big[31] == lit[31])
        begin
            mag = bm + sm;
            sgn = big[31];
        end
        else if (bm >= sm)
        begin
            mag = bm - sm;
            sgn = big[31];
        end
        else
        begin
            mag = sm - bm;
            sgn = lit[31];
        end
        if (mag == 128'd0)
        begin
            sgn = a[31] & b[31];
        end
        return fp32_round_pack(sgn, mag, fp32_exp(big) - s);
    endfunction

    function automatic int clamp_dim(input logic [DIM_W-1:0] d);
        if (d < 1)
        begin
            return 1;
        end
        if (d > MAX_DIM_DEF)
        begin
            return MAX_DIM_DEF;
        end
        return int'(d);
    endfunction

    task automatic queue_products();
        int          m;
        int          kk;
        int          n;
        logic [31:0] acc;
        out_word_t   w;
        m  = clamp_dim(rows_reg);
        kk = clamp_dim(inner_reg);
        n  = clamp_dim(cols_reg);
        for (int i = 0; i < m; i++)
        begin
            for (int j = 0; j < n; j++)
            begin
                acc = FP_ZERO;
                for (int k = 0; k < kk; k++)
                begin
                    acc = fp32_add(acc, fp32_mul(a_copy[i * kk + k], b_copy[k * n + j]));
                end
                if (fp32_is_nan(acc))
                begin
                    acc = CANON_NAN;
                end
                w.product_value = acc;
                w.is_last       = (i == m - 1 && j == n - 1);
                product_queue.push_back(w);
            end
        end
    endtask

    function automatic bit sender_idle();
        if (idle_mode == 1)
        begin
            return $urandom_range(0, 99) < 83;
        end
        if (idle_mode == 3)
        begin
            return $urandom_range(0, 99) < 14;
        end
        return 1'b0;
    endfunction

    function automatic bit receiver_stall();
        if (idle_mode == 2)
        begin
            return $urandom_range(0, 99) < 83;
        end
        if (idle_mode == 3)
        begin
            return $urandom_range(0, 99) < 14;
        end
        return 1'b0;
    endfunction

    function automatic logic [31:0] random_fp32();
        logic [31:0] specials [8];
        specials = '{32'h0000_0000, 32'h8000_0000, 32'h7F80_0000, 32'hFF80_0000,
                     32'h7FC0_0001, 32'h0000_0001, 32'h807F_FFFF, 32'h7F7F_FFFF};
        case ($urandom_range(0, 7))
            0: return $urandom;
            1: return specials[$urandom_range(0, 7)];
            2: return {1'($urandom), 8'($urandom_range(0, 20)), 23'($urandom)};
            default: return {1'($urandom), 8'($urandom_range(118, 136)), 23'($urandom)};
        endcase
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("result %0d: %s got %h expected %h", results_seen, what, got, want);
        errors++;
    endtask

    task automatic send_word(input in_word_t w, input bit typed, input logic [31:0] product);
        out_word_t e;
        while (sender_idle())
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        in_word  <= w;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        words_sent++;
        if (w.kind == KIND_LOAD_A)
        begin
            a_copy[w.element_index]    = w.element_value;
            a_written[w.element_index] = 1'b1;
        end
        else if (w.kind == KIND_LOAD_B)
        begin
            b_copy[w.element_index]    = w.element_value;
            b_written[w.element_index] = 1'b1;
        end
        else if (w.kind == KIND_START)
        begin
            starts_sent++;
            if (typed)
            begin
                e.product_value = product;
                e.is_last       = 1'b1;
                product_queue.push_back(e);
            end
            else
            begin
                queue_products();
            end
        end
    endtask

    task automatic send_load(input logic [KIND_W-1:0] kind, input int index);
        in_word_t w;
        w.kind          = kind;
        w.element_index = IDX_W'(index);
        w.element_value = random_fp32();
        send_word(w, 1'b0, FP_ZERO);
    endtask

    task automatic send_start();
        in_word_t w;
        int       m;
        int       kk;
        int       n;
        m  = clamp_dim(rows_reg);
        kk = clamp_dim(inner_reg);
        n  = clamp_dim(cols_reg);
        for (int i = 0; i < m * kk; i++)
        begin
            if (!a_written[i])
            begin
                send_load(KIND_LOAD_A, i);
            end
        end
        for (int i = 0; i < kk * n; i++)
        begin
            if (!b_written[i])
            begin
                send_load(KIND_LOAD_B, i);
            end
        end
        w.kind          = KIND_START;
        w.element_index = IDX_W'($urandom);
        w.element_value = $urandom;
        send_word(w, 1'b0, FP_ZERO);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        while (product_queue.size() != 0)
        begin
            @(posedge clk);
        end
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] index, input logic [DIM_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data  <= data;
        @(posedge clk);
        while (!cfg_ready)
        begin
            @(posedge clk);
        end
        if (index == REG_ROWS)
        begin
            rows_reg = data;
        end
        else if (index == REG_INNER)
        begin
            inner_reg = data;
        end
        else if (index == REG_COLS)
        begin
            cols_reg = data;
        end
    endtask

    always @(posedge clk)
    begin
        out_stall <= receiver_stall();
    end

    always @(posedge clk)
    begin
        if (out_valid && !out_stall)
        begin
            if (product_queue.size() == 0)
            begin
                report_mismatch("unexpected word", out_word.product_value, FP_ZERO);
            end
            else
            begin
                if (out_word.product_value !== product_queue[0].product_value)
                begin
                    report_mismatch("product_value", out_word.product_value,
                                    product_queue[0].product_value);
                end
                if (out_word.is_last !== product_queue[0].is_last)
                begin
                    report_mismatch("is_last", 32'(out_word.is_last),
                                    32'(product_queue[0].is_last));
                end
                void'(product_queue.pop_front());
            end
            results_seen++;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)
            || (cfg_valid && cfg_ready))
        begin
            quiet_cycles <= 0;
        end
        else if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("float_matrix_multiply_top: mismatch");
            $finish;
        end
        else
        begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        stim_row_t   rows [$];
        logic [3:0]  dims [12][3];
        in_word_t    w;
        int          m;
        int          kk;
        int          n;
        int          r;
        rows = '{
            '{KIND_LOAD_A, 6'd0, 32'h3F80_0000, 1'b0, FP_ZERO},
            '{KIND_LOAD_B, 6'd0, 32'h4000_0000, 1'b0, FP_ZERO},
            '{KIND_START, 6'd0, 32'h0000_0000, 1'b1, 32'h4000_0000},
            '{KIND_LOAD_A, 6'd0, 32'h7F80_0000, 1'b0, FP_ZERO},
            '{KIND_LOAD_B, 6'd0, 32'h0000_0000, 1'b0, FP_ZERO},
            '{KIND_START, 6'd63, 32'hFFFF_FFFF, 1'b1, CANON_NAN},
            '{KIND_LOAD_A, 6'd0, 32'h7F7F_FFFF, 1'b0, FP_ZERO},
            '{KIND_LOAD_B, 6'd0, 32'h4000_0000, 1'b0, FP_ZERO},
            '{KIND_START, 6'd0, 32'h0000_0000, 1'b1, 32'h7F80_0000},
            '{KIND_LOAD_A, 6'd0, 32'hFFFF_FFFF, 1'b0, FP_ZERO},
            '{KIND_LOAD_B, 6'd0, 32'h3F80_0000, 1'b0, FP_ZERO},
            '{KIND_START, 6'd0, 32'h0000_0000, 1'b1, CANON_NAN},
            '{KIND_LOAD_A, 6'd0, 32'h8000_0000, 1'b0, FP_ZERO},
            '{KIND_START, 6'd0, 32'h0000_0000, 1'b1, FP_ZERO},
            '{KIND_LOAD_A, 6'd0, 32'h0000_0001, 1'b0, FP_ZERO},
            '{KIND_LOAD_B, 6'd0, 32'h3F00_0000, 1'b0, FP_ZERO},
            '{KIND_START, 6'd0, 32'h0000_0000, 1'b0, FP_ZERO},
            '{KIND_UNUSED, 6'd0, 32'hFFFF_FFFF, 1'b0, FP_ZERO},
            '{KIND_LOAD_A, 6'd63, 32'hC2F6_E979, 1'b0, FP_ZERO},
            '{KIND_LOAD_B, 6'd63, 32'h0080_0000, 1'b0, FP_ZERO},
            '{KIND_START, 6'd0, 32'h0000_0000, 1'b0, FP_ZERO}
        };
        dims = '{'{4'd1, 4'd1, 4'd1}, '{4'd8, 4'd8, 4'd8}, '{4'd0, 4'd0, 4'd0},
                 '{4'd15, 4'd9, 4'd12}, '{4'd2, 4'd3, 4'd4}, '{4'd8, 4'd1, 4'd8},
                 '{4'd1, 4'd8, 4'd1}, '{4'd3, 4'd2, 4'd5}, '{4'd4, 4'd4, 4'd2},
                 '{4'd2, 4'd2, 4'd2}, '{4'd5, 4'd3, 4'd1}, '{4'd1, 4'd2, 4'd3}};
        errors       = 0;
        words_sent   = 0;
        starts_sent  = 0;
        results_seen = 0;
        idle_mode    = 0;
        rows_reg     = 4'd1;
        inner_reg    = 4'd1;
        cols_reg     = 4'd1;
        for (int i = 0; i < STORE_DEPTH; i++)
        begin
            a_written[i] = 1'b0;
            b_written[i] = 1'b0;
        end
        rst_n     = 1'b0;
        in_valid  = 1'b0;
        in_word   = '0;
        out_stall = 1'b0;
        cfg_valid = 1'b0;
        cfg_index = REG_ROWS;
        cfg_data  = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[i])
        begin
            w.kind          = rows[i].kind;
            w.element_index = rows[i].index;
            w.element_value = rows[i].value;
            send_word(w, rows[i].typed, rows[i].product);
        end

        for (int seg = 0; seg < 12; seg++)
        begin
            drain_results();
            idle_mode = seg / 3;
            if (seg >= 8)
            begin
                for (int d = 0; d < 3; d++)
                begin
                    dims[seg][d] = 4'($urandom_range(1, 4));
                end
            end
            write_reg(REG_ROWS, dims[seg][0]);
            write_reg(REG_INNER, dims[seg][1]);
            write_reg(REG_COLS, dims[seg][2]);
            if (seg % 4 == 1)
            begin
                write_reg(REG_UNUSED, 4'($urandom));
            end
            cfg_valid <= 1'b0;
            m  = clamp_dim(rows_reg);
            kk = clamp_dim(inner_reg);
            n  = clamp_dim(cols_reg);
            for (int item = 0; item < 16; item++)
            begin
                r = $urandom_range(0, 99);
                if (r < 40)
                begin
                    send_load(KIND_LOAD_A, (r < 32) ? $urandom_range(0, m * kk - 1)
                                                    : $urandom_range(0, STORE_DEPTH - 1));
                end
                else if (r < 80)
                begin
                    send_load(KIND_LOAD_B, (r < 72) ? $urandom_range(0, kk * n - 1)
                                                    : $urandom_range(0, STORE_DEPTH - 1));
                end
                else if (r < 85)
                begin
                    w.kind          = KIND_UNUSED;
                    w.element_index = IDX_W'($urandom);
                    w.element_value = $urandom;
                    send_word(w, 1'b0, FP_ZERO);
                end
                else
                begin
                    send_start();
                end
            end
            send_start();
        end

        drain_results();
        repeat (50) @(posedge clk);
        $display("Sent %0d input words including %0d starts over twelve dimension settings,",
                 words_sent, starts_sent);
        $display("and checked %0d result words under four idling patterns.", results_seen);
        if (errors == 0 && product_queue.size() == 0)
        begin
            $display("float_matrix_multiply_top: match");
        end
        else
        begin
            $display("float_matrix_multiply_top: mismatch");
        end
        $finish;
    end

endmodule
